// ----- src/sbph_pkg.sv -----
// Shared widths, register indexes, defaults and control types of the spectrum bar peak hold unit.
package sbph_pkg;

  localparam int unsigned NumBinsDefault = 128;

  localparam int unsigned RawW     = 8;
  localparam int unsigned LevelW   = 6;
  localparam int unsigned TimerW   = 7;
  localparam int unsigned FrameW   = 8;
  localparam int unsigned CfgDataW = 8;
  localparam int unsigned CfgIdxW  = 1;

  // Width of the remainder unit's divisor: a fall period of zero reads as 256.
  localparam int unsigned PeriodW  = FrameW + 1;
  localparam int unsigned ModCntW  = $clog2(FrameW);

  localparam logic [CfgIdxW-1:0] CfgFallPeriod = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgHoldFrames = 1'b1;

  localparam logic [FrameW-1:0] FallPeriodReset = 8'd4;
  localparam logic [TimerW-1:0] HoldFramesReset = 7'd7;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic mod_start;
    logic mod_step;
    logic calc;
  } sbph_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
    logic ptr_zero;
    logic fall_known;
    logic mod_last;
  } sbph_sts_t;

endpackage

// ----- src/spectrum_bar_peak_hold_unit.sv -----
// Top level of the spectrum bar peak hold unit: controller and datapath.
//
// Takes one raw magnitude byte per spectrum bin, bins in order, NUM_BINS bins a frame, and
// returns for each the bin's smoothed bar level, its held falling peak and an end-of-frame
// flag. A bin normally takes an accept step, which transfers the byte in and reads the bin's
// stores from the single-port store memory, and an update step that writes them back. The
// first bin of every frame, and the first bin after fall_period is written, also passes
// through an eight-step remainder unit, which works out whether the frame is a fall frame. A
// new byte can be accepted in the same cycle as the previous result is transferred out. After
// reset the stores read as zero until the first frame has been completed; there is no
// clearing pass.
module spectrum_bar_peak_hold_unit import sbph_pkg::*; #(
  parameter int unsigned NUM_BINS = NumBinsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [RawW-1:0]     raw_magnitude_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [LevelW-1:0]   bar_level_o,
  output logic [LevelW-1:0]   peak_level_o,
  output logic                frame_end_o
);

  sbph_cmd_t cmd;
  sbph_sts_t sts;

  sbph_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sbph_datapath #(
    .NUM_BINS (NUM_BINS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .raw_magnitude_i (raw_magnitude_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .bar_level_o     (bar_level_o),
    .peak_level_o    (peak_level_o),
    .frame_end_o     (frame_end_o),
    .cmd_i           (cmd),
    .sts_o           (sts)
  );

endmodule

// ----- src/sbph_ctrl.sv -----
// Controller state machine that sequences accept, remainder steps and the bin update.
module sbph_ctrl import sbph_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  sbph_sts_t sts_i,
  output sbph_cmd_t cmd_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StMod  = 2'd1;
  localparam logic [1:0] StCalc = 2'd2;

  logic [1:0] state_q, state_d;
  logic       accept;

  assign in_ready_o = (state_q == StIdle) && sts_i.out_free;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d         = state_q;
    cmd_o           = '0;
    cmd_o.accept    = accept;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          // The fall decision is refreshed at each frame start and after a period change.
          if (sts_i.ptr_zero || !sts_i.fall_known) begin
            cmd_o.mod_start = 1'b1;
            state_d         = StMod;
          end else begin
            state_d = StCalc;
          end
        end
      end
      StMod: begin
        cmd_o.mod_step = 1'b1;
        if (sts_i.mod_last) begin
          state_d = StCalc;
        end
      end
      StCalc: begin
        cmd_o.calc = 1'b1;
        state_d    = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- src/sbph_datapath.sv -----
// Datapath: bin stores, frame counter, remainder unit, configuration and output register.
module sbph_datapath import sbph_pkg::*; #(
  parameter int unsigned NUM_BINS = NumBinsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic [RawW-1:0]     raw_magnitude_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [LevelW-1:0]   bar_level_o,
  output logic [LevelW-1:0]   peak_level_o,
  output logic                frame_end_o,
  input  sbph_cmd_t           cmd_i,
  output sbph_sts_t           sts_o
);

  localparam int unsigned BinW  = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam int unsigned WordW = TimerW + 2 * LevelW;

  // Configuration registers.
  logic [FrameW-1:0] fall_period_q;
  logic [TimerW-1:0] hold_frames_q;

  // Bin stores held as one word per bin: {timer, peak, level}.
  logic [WordW-1:0] store_mem [NUM_BINS];
  logic [WordW-1:0] rd_q;
  logic [WordW-1:0] wr_word;

  logic [BinW-1:0]   bin_ptr_q;
  logic [FrameW-1:0] frame_cnt_q;
  logic [FrameW-1:0] frame_cnt_d;
  logic              filled_q;
  logic [LevelW-1:0] target_q;
  logic              last_bin;

  // Remainder unit.
  logic [PeriodW-1:0] divisor;
  logic [PeriodW-1:0] rem_q, rem_shift, rem_d;
  logic [FrameW-1:0]  dvd_q;
  logic [ModCntW-1:0] mod_cnt_q;
  logic               fall_flag_q;
  logic               fall_known_q;

  // Update arithmetic.
  logic [LevelW-1:0] level_old, peak_old, level_new, peak_new;
  logic [TimerW-1:0] timer_old, timer_new;

  logic out_valid_q;

  assign last_bin    = (bin_ptr_q == BinW'(NUM_BINS - 1));
  assign frame_cnt_d = frame_cnt_q + FrameW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fall_period_q <= FallPeriodReset;
      hold_frames_q <= HoldFramesReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgFallPeriod: fall_period_q <= cfg_data_i;
        CfgHoldFrames: hold_frames_q <= cfg_data_i[TimerW-1:0];
        default: ;
      endcase
    end
  end

  // A period of zero counts as 256, so only the wrapped counter value gives remainder zero.
  assign divisor   = {(fall_period_q == '0), fall_period_q};
  assign rem_shift = {rem_q[PeriodW-2:0], dvd_q[FrameW-1]};
  assign rem_d     = (rem_shift >= divisor) ? (rem_shift - divisor) : rem_shift;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_cnt_q  <= '0;
      bin_ptr_q    <= '0;
      filled_q     <= 1'b0;
      mod_cnt_q    <= '0;
      fall_flag_q  <= 1'b0;
      fall_known_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.accept && (bin_ptr_q == '0)) begin
        frame_cnt_q <= frame_cnt_d;
      end
      if (cmd_i.mod_start) begin
        mod_cnt_q <= '0;
      end else if (cmd_i.mod_step) begin
        mod_cnt_q <= mod_cnt_q + ModCntW'(1);
        if (sts_o.mod_last) begin
          fall_flag_q  <= (rem_d == '0);
          fall_known_q <= 1'b1;
        end
      end
      if (cfg_we_i && (cfg_index_i == CfgFallPeriod)) begin
        fall_known_q <= 1'b0;
      end
      if (cmd_i.calc) begin
        bin_ptr_q <= last_bin ? '0 : bin_ptr_q + BinW'(1);
        if (last_bin) begin
          filled_q <= 1'b1;
        end
      end
      if (cmd_i.calc) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Remainder shift registers; the dividend is the counter value of the frame being worked.
  always_ff @(posedge clk_i) begin
    if (cmd_i.mod_start) begin
      rem_q <= '0;
      dvd_q <= (bin_ptr_q == '0) ? frame_cnt_d : frame_cnt_q;
    end else if (cmd_i.mod_step) begin
      rem_q <= rem_d;
      dvd_q <= {dvd_q[FrameW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      rd_q     <= store_mem[bin_ptr_q];
      target_q <= raw_magnitude_i[RawW-1:2];
    end
    if (cmd_i.calc) begin
      store_mem[bin_ptr_q] <= wr_word;
    end
  end

  // Bins are visited in order, so until the first frame is complete every entry reads as zero.
  assign level_old = filled_q ? rd_q[LevelW-1:0]          : '0;
  assign peak_old  = filled_q ? rd_q[2*LevelW-1:LevelW]   : '0;
  assign timer_old = filled_q ? rd_q[WordW-1:2*LevelW]    : '0;

  always_comb begin
    if (target_q > level_old) begin
      level_new = level_old + LevelW'(1);
    end else if (target_q < level_old) begin
      level_new = level_old - LevelW'(1);
    end else begin
      level_new = level_old;
    end
    peak_new  = peak_old;
    timer_new = timer_old;
    if (level_new >= peak_old) begin
      peak_new  = level_new;
      timer_new = hold_frames_q;
    end else if (fall_flag_q) begin
      if (timer_old == '0) begin
        peak_new = peak_old - LevelW'(1);
      end else begin
        timer_new = timer_old - TimerW'(1);
      end
    end
  end

  assign wr_word = {timer_new, peak_new, level_new};

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc) begin
      bar_level_o  <= level_new;
      peak_level_o <= peak_new;
      frame_end_o  <= last_bin;
    end
  end

  assign out_valid_o = out_valid_q;

  assign sts_o.out_free   = !out_valid_q || out_ready_i;
  assign sts_o.ptr_zero   = (bin_ptr_q == '0);
  assign sts_o.fall_known = fall_known_q;
  assign sts_o.mod_last   = (mod_cnt_q == ModCntW'(FrameW - 1));

endmodule

// ----- tb/spectrum_bar_peak_hold_unit_tb.sv -----
// Self-checking testbench for the spectrum bar peak hold unit, with a per-bin predictor.
module spectrum_bar_peak_hold_unit_tb import sbph_pkg::*;;

  localparam int unsigned NumBins    = NumBinsDefault;
  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned SqueezeLen = 300;

  typedef struct packed {
    logic [LevelW-1:0] bar;
    logic [LevelW-1:0] peak;
    logic              last_bin;
  } bin_result_t;

  typedef enum int unsigned {
    FrameNoise,
    FrameLow,
    FrameHigh,
    FrameGoal
  } frame_shape_e;

  // Tracks every bin's bar, peak and hold timer, and the expected results in transfer order.
  class bar_peak_scoreboard;
    logic [LevelW-1:0] level_mem [NumBins];
    logic [LevelW-1:0] peak_mem  [NumBins];
    logic [TimerW-1:0] timer_mem [NumBins];
    logic [FrameW-1:0] frame_cnt;
    int unsigned       bin_idx;
    logic [FrameW-1:0] fall_period;
    logic [TimerW-1:0] hold_frames;
    bin_result_t       expected_q [$];
    int unsigned       mismatches;

    function new();
      for (int unsigned b = 0; b < NumBins; b++) begin
        level_mem[b] = '0;
        peak_mem[b]  = '0;
        timer_mem[b] = '0;
      end
      frame_cnt   = '0;
      bin_idx     = 0;
      fall_period = FallPeriodReset;
      hold_frames = HoldFramesReset;
      mismatches  = 0;
    endfunction

    function void write_register(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        CfgFallPeriod: fall_period = data;
        CfgHoldFrames: hold_frames = data[TimerW-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void note_input(logic [RawW-1:0] raw);
      logic [LevelW-1:0] goal;
      logic [LevelW-1:0] lvl;
      logic [LevelW-1:0] pk;
      logic [TimerW-1:0] tmr;
      int unsigned       period;
      bin_result_t       res;
      goal = raw[RawW-1:2];
      if (bin_idx == 0) frame_cnt = frame_cnt + 1'b1;
      lvl = level_mem[bin_idx];
      if (goal > lvl) lvl = lvl + 1'b1;
      else if (goal < lvl) lvl = lvl - 1'b1;
      pk  = peak_mem[bin_idx];
      tmr = timer_mem[bin_idx];
      // A fall period of zero behaves as 256, so only a wrapped counter of zero qualifies.
      period = (fall_period == '0) ? 256 : int'(fall_period);
      if (lvl >= pk) begin
        pk  = lvl;
        tmr = hold_frames;
      end else if ((int'(frame_cnt) % period) == 0) begin
        if (tmr == '0) pk = pk - 1'b1;
        else tmr = tmr - 1'b1;
      end
      level_mem[bin_idx] = lvl;
      peak_mem[bin_idx]  = pk;
      timer_mem[bin_idx] = tmr;
      res.bar      = lvl;
      res.peak     = pk;
      res.last_bin = (bin_idx == NumBins - 1);
      expected_q.push_back(res);
      bin_idx = res.last_bin ? 0 : bin_idx + 1;
    endfunction

    task report_mismatch(string msg);
      if (mismatches < 30) $display("[%0t] mismatch: %s", $time, msg);
      mismatches++;
    endtask

    task check_result(logic [LevelW-1:0] bar, logic [LevelW-1:0] peak, logic last_bin);
      bin_result_t want;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result bar %0d peak %0d end %0b",
                                  bar, peak, last_bin));
        return;
      end
      want = expected_q.pop_front();
      if (bar !== want.bar)
        report_mismatch($sformatf("bar_level %0d, expected %0d", bar, want.bar));
      if (peak !== want.peak)
        report_mismatch($sformatf("peak_level %0d, expected %0d", peak, want.peak));
      if (last_bin !== want.last_bin)
        report_mismatch($sformatf("frame_end %0b, expected %0b", last_bin, want.last_bin));
    endtask
  endclass

  logic                clk_i           = 1'b0;
  logic                rst_ni          = 1'b0;
  logic                cfg_we_i        = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i     = '0;
  logic [CfgDataW-1:0] cfg_data_i      = '0;
  logic                in_valid_i      = 1'b0;
  logic                in_ready_o;
  logic [RawW-1:0]     raw_magnitude_i = '0;
  logic                out_valid_o;
  logic                out_ready_i     = 1'b0;
  logic [LevelW-1:0]   bar_level_o;
  logic [LevelW-1:0]   peak_level_o;
  logic                frame_end_o;

  bar_peak_scoreboard sb = new();

  bit           calm            = 1'b0;
  bit           hold_off_request = 1'b0;
  frame_shape_e frame_shape     = FrameGoal;
  logic [RawW-1:0] bin_goal [NumBins];
  int unsigned  cycle_count     = 0;

  spectrum_bar_peak_hold_unit #(
    .NUM_BINS(NumBins)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .raw_magnitude_i(raw_magnitude_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .bar_level_o    (bar_level_o),
    .peak_level_o   (peak_level_o),
    .frame_end_o    (frame_end_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int unsigned idle_len();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // In half of the frames each bin chases a goal of its own over several frames, so that peaks rise, hold
  // and fall; some frames are pure noise or drive every bin to the floor or the ceiling.
  function automatic logic [RawW-1:0] next_raw();
    int unsigned b;
    int unsigned r;
    b = sb.bin_idx;
    if (b == 0) begin
      r = $urandom_range(0, 9);
      if (r < 2) frame_shape = FrameNoise;
      else if (r < 4) frame_shape = FrameLow;
      else if (r < 5) frame_shape = FrameHigh;
      else frame_shape = FrameGoal;
    end
    if ($urandom_range(0, 9) == 0) begin
      r = $urandom_range(0, 2);
      bin_goal[b] = (r == 0) ? 8'h00 : (r == 1) ? 8'hFF : RawW'($urandom);
    end
    case (frame_shape)
      FrameNoise: return RawW'($urandom);
      FrameLow:   return RawW'($urandom_range(0, 3));
      FrameHigh:  return RawW'($urandom_range(252, 255));
      default:    return {bin_goal[b][RawW-1:2], 2'($urandom)};
    endcase
  endfunction

  task automatic send_bin(input logic [RawW-1:0] raw);
    int unsigned gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    raw_magnitude_i <= raw;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_input(raw);
  endtask

  task automatic wait_idle();
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // Both registers in consecutive cycles; only called once every result has come back.
  task automatic write_settings(input logic [FrameW-1:0] fall, input logic [CfgDataW-1:0] hold);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CfgFallPeriod;
    cfg_data_i  <= fall;
    @(posedge clk_i);
    sb.write_register(CfgFallPeriod, fall);
    cfg_index_i <= CfgHoldFrames;
    cfg_data_i  <= hold;
    @(posedge clk_i);
    sb.write_register(CfgHoldFrames, hold);
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_phase(input logic [FrameW-1:0] fall, input logic [TimerW-1:0] hold,
                           input int unsigned n, input bit quiet, input bit squeeze);
    wait_idle();
    write_settings(fall, {1'($urandom), hold});
    calm = quiet;
    if (squeeze) hold_off_request = 1'b1;
    repeat (n) send_bin(next_raw());
    in_valid_i <= 1'b0;
  endtask

  task automatic directed_part();
    logic [RawW-1:0] opening [16];
    logic [RawW-1:0] closing [9];
    opening = '{8'hFF, 8'h00, 8'h55, 8'hAA, 8'h03, 8'h04, 8'hFC, 8'hFB,
                8'h80, 8'h7F, 8'h01, 8'hFE, 8'h40, 8'hBF, 8'hFF, 8'h00};
    closing = '{8'hFF, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'hAA, 8'h55, 8'hFC, 8'h03};
    calm = 1'b0;
    // Reset values of both registers first, then a fall period of zero with the widest hold.
    foreach (opening[i]) send_bin(opening[i]);
    in_valid_i <= 1'b0;
    wait_idle();
    write_settings('0, 8'hFF);
    foreach (closing[i]) send_bin(closing[i]);
    in_valid_i <= 1'b0;
  endtask

  // Output side: checks each transfer and decides readiness for the next cycle.
  initial begin
    int unsigned stall_left;
    int unsigned hold_left;
    stall_left = 0;
    hold_left  = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i)
        sb.check_result(bar_level_o, peak_level_o, frame_end_o);
      if (hold_off_request) begin
        hold_left        = SqueezeLen;
        hold_off_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        stall_left = ($urandom_range(0, 3) == 0) ? idle_len() : 0;
        out_ready_i <= (stall_left == 0);
      end
    end
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("spectrum_bar_peak_hold_unit_tb: FAIL");
    $finish;
  end

  initial begin
    foreach (bin_goal[b]) bin_goal[b] = RawW'($urandom);
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    directed_part();
    run_phase(8'd1,   7'd0,   260, 1'b0, 1'b0);
    run_phase(8'd255, 7'd1,   240, 1'b0, 1'b0);
    run_phase(8'd2,   7'd127, 250, 1'b0, 1'b0);
    // The sender keeps offering while the output side is held off, so the input stalls.
    run_phase(8'd1,   7'd3,   300, 1'b1, 1'b1);
    run_phase(8'd3,   7'd0,   250, 1'b1, 1'b0);
    run_phase(8'd128, 7'd64,  200, 1'b0, 1'b0);
    run_phase(8'd1,   7'd0,   370, 1'b0, 1'b0);
    wait_idle();
    repeat (20) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("spectrum_bar_peak_hold_unit_tb: PASS");
    end else begin
      $display("spectrum_bar_peak_hold_unit_tb: FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/sbph_pkg.sv
src/sbph_ctrl.sv
src/sbph_datapath.sv
src/spectrum_bar_peak_hold_unit.sv
tb/spectrum_bar_peak_hold_unit_tb.sv
